// ===== rtl/length_prefixed_slice_deframer_top_defines.svh =====
// Assertion macros shared by the deframer RTL files.
`ifndef LENGTH_PREFIXED_SLICE_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_SLICE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lpsd_pkg.sv =====
// Package: constants and types of the length-prefixed slice deframer.
`default_nettype none
package lpsd_pkg;

   // Header length in bytes (size and sequence id live in the first eight)
   localparam int unsigned LPSD_HEADER_BYTES = 28;
   localparam logic [31:0] LPSD_HEADER_LEN   = 32'(LPSD_HEADER_BYTES);

   // Default depth of the queue between front and back
   localparam int unsigned LPSD_QUEUE_DEPTH = 2;

   // Reset value of the frames-per-group register
   localparam logic [15:0] LPSD_FPG_RESET = 16'd1;

   // Item kinds produced by the front
   localparam logic LPSD_KIND_DATA    = 1'b0;
   localparam logic LPSD_KIND_RESTART = 1'b1;

   // Classified item travelling through the queue
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } item_type;

   // One result item
   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  data_out;
      logic        in_header;
      logic        frame_done;
      logic        group_done;
      logic        sequence_mismatch;
      logic        size_error;
      logic [31:0] frame_seq_id;
      logic [31:0] group_bytes;
      logic [15:0] frames_in_group;
      logic [31:0] groups_done;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/lpsd_if.sv =====
// Interfaces: request, response and register-write channels.
`default_nettype none

interface lpsd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface lpsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        byte_valid;
   logic [7:0]  data_out;
   logic        in_header;
   logic        frame_done;
   logic        group_done;
   logic        sequence_mismatch;
   logic        size_error;
   logic [31:0] frame_seq_id;
   logic [31:0] group_bytes;
   logic [15:0] frames_in_group;
   logic [31:0] groups_done;

   modport source (output valid, output byte_valid, output data_out, output in_header,
                   output frame_done, output group_done, output sequence_mismatch,
                   output size_error, output frame_seq_id, output group_bytes,
                   output frames_in_group, output groups_done, input ready);
   modport sink   (input valid, input byte_valid, input data_out, input in_header,
                   input frame_done, input group_done, input sequence_mismatch,
                   input size_error, input frame_seq_id, input group_bytes,
                   input frames_in_group, input groups_done, output ready);
endinterface

interface lpsd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpsd_front.sv =====
// Front: accept request transfers, classify them and hand them to the queue.
`default_nettype none
module lpsd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   lpsd_req_if.sink               req_ch,
   output lpsd_pkg::item_type     q_item,
   output logic                   q_valid,
   input  wire logic              q_ready
);
   import lpsd_pkg::*;

   logic     slot_valid_ff;
   logic     slot_valid_in;
   item_type slot_ff;
   item_type slot_in;

   // Take a new transfer whenever the slot is empty or drains this cycle
   assign req_ch.ready = !slot_valid_ff || q_ready;

   // Classify: restart command or data byte
   always_comb begin
      slot_in.kind      = req_ch.cmd ? LPSD_KIND_RESTART : LPSD_KIND_DATA;
      slot_in.data_byte = req_ch.data_byte;
   end

   assign slot_valid_in = req_ch.ready ? req_ch.valid : slot_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // Hold payload unless a new transfer lands
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         slot_ff <= slot_in;
      end
   end

   assign q_item  = slot_ff;
   assign q_valid = slot_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/lpsd_queue.sv =====
// Queue: short register FIFO between the front and the back.
`default_nettype none
module lpsd_queue #(
   parameter int unsigned DEPTH = lpsd_pkg::LPSD_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lpsd_pkg::item_type push_item,
   input  wire logic              push_valid,
   output logic                   push_ready,
   output lpsd_pkg::item_type     pop_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready
);
   import lpsd_pkg::*;

   `include "length_prefixed_slice_deframer_top_defines.svh"

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   item_type          store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = store_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Advance pointers with wrap at the last entry
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   `LPSD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL,
                    "queue count over depth")
   `LPSD_ASSERT_NEXT(a_push_grows, clock, reset, do_push && !do_pop,
                     count_ff == $past(count_ff) + CNT_ONE, "push did not grow queue")
   `LPSD_ASSERT_NEXT(a_pop_shrinks, clock, reset, do_pop && !do_push,
                     count_ff == $past(count_ff) - CNT_ONE, "pop did not shrink queue")
   `LPSD_ASSERT_NOW(a_ptr_match, clock, reset, count_ff == '0 || count_ff == CNT_FULL,
                    wr_ptr_ff == rd_ptr_ff, "pointers disagree with count")

endmodule
`default_nettype wire

// ===== rtl/lpsd_back.sv =====
// Back: deframing state, sequence check, group counting and result register.
`default_nettype none
module lpsd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lpsd_pkg::item_type pop_item,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   lpsd_csr_if.sink                csr_ch,
   lpsd_rsp_if.source              rsp_ch
);
   import lpsd_pkg::*;

   `include "length_prefixed_slice_deframer_top_defines.svh"

   // Configuration
   logic [15:0] fpg_ff;

   // Deframing state
   logic        payload_phase_ff,  payload_phase_in;
   logic [31:0] frame_count_ff,    frame_count_in;
   logic [31:0] frame_size_ff,     frame_size_in;
   logic [31:0] seq_shift_ff,      seq_shift_in;
   logic [31:0] prev_seq_ff,       prev_seq_in;
   logic        seq_latched_ff,    seq_latched_in;
   logic [15:0] grp_frames_ff,     grp_frames_in;
   logic [31:0] grp_bytes_ff,      grp_bytes_in;
   logic [31:0] groups_ff,         groups_in;

   // Result register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic        take;
   logic [31:0] pos_next;
   logic [31:0] bytes_sat;
   logic [15:0] frames_inc;
   logic        fdone;
   logic        gdone;
   logic        mism;
   logic        serr;
   logic [7:0]  b;

   assign csr_ch.ready = 1'b1;
   assign pop_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign take         = pop_valid && pop_ready;
   assign b            = pop_item.data_byte;

   always_comb begin
      payload_phase_in = payload_phase_ff;
      frame_count_in   = frame_count_ff;
      frame_size_in    = frame_size_ff;
      seq_shift_in     = seq_shift_ff;
      prev_seq_in      = prev_seq_ff;
      seq_latched_in   = seq_latched_ff;
      grp_frames_in    = grp_frames_ff;
      grp_bytes_in     = grp_bytes_ff;
      groups_in        = groups_ff;
      fdone            = 1'b0;
      gdone            = 1'b0;
      mism             = 1'b0;
      serr             = 1'b0;
      pos_next         = frame_count_ff + 32'd1;
      bytes_sat        = (grp_bytes_ff == 32'hFFFF_FFFF) ? grp_bytes_ff
                                                         : grp_bytes_ff + 32'd1;
      frames_inc       = grp_frames_ff + 16'd1;
      rsp_in           = '0;

      if (pop_item.kind == LPSD_KIND_RESTART) begin
         // Drop the run: clear all run state, result all zero
         payload_phase_in = 1'b0;
         frame_count_in   = '0;
         frame_size_in    = '0;
         seq_shift_in     = '0;
         prev_seq_in      = '0;
         seq_latched_in   = 1'b0;
         grp_frames_in    = '0;
         grp_bytes_in     = '0;
         groups_in        = '0;
      end else begin
         grp_bytes_in = bytes_sat;
         if (!payload_phase_ff) begin
            // Header byte: pick up size and sequence id from the first eight
            if (frame_count_ff[31:3] == '0) begin
               case (frame_count_ff[2:0])
                  3'd0: begin
                     frame_size_in = {24'd0, b};
                     seq_shift_in  = '0;
                  end
                  3'd1: frame_size_in[15:8]  = b;
                  3'd2: frame_size_in[23:16] = b;
                  3'd3: frame_size_in[31:24] = b;
                  3'd4: seq_shift_in[7:0]    = b;
                  3'd5: seq_shift_in[15:8]   = b;
                  3'd6: seq_shift_in[23:16]  = b;
                  3'd7: seq_shift_in[31:24]  = b;
                  default: frame_size_in = frame_size_ff;
               endcase
            end
            frame_count_in = pos_next;
            if (pos_next >= LPSD_HEADER_LEN) begin
               // Last header byte: check sequence and size
               if (seq_latched_ff && (seq_shift_in != prev_seq_ff + 32'd1)) begin
                  mism = 1'b1;
               end else begin
                  seq_latched_in = 1'b1;
               end
               prev_seq_in = seq_shift_in;
               serr        = (frame_size_in < LPSD_HEADER_LEN);
               if (frame_size_in <= LPSD_HEADER_LEN) begin
                  fdone          = 1'b1;
                  frame_count_in = '0;
               end else begin
                  payload_phase_in = 1'b1;
               end
            end
         end else begin
            // Payload byte: end the frame at its size
            frame_count_in = pos_next;
            if (pos_next >= frame_size_ff) begin
               fdone            = 1'b1;
               frame_count_in   = '0;
               payload_phase_in = 1'b0;
            end
         end

         if (fdone) begin
            grp_frames_in = frames_inc;
            gdone         = (frames_inc == fpg_ff);
         end

         rsp_in.byte_valid        = 1'b1;
         rsp_in.data_out          = b;
         rsp_in.in_header         = !payload_phase_ff;
         rsp_in.frame_done        = fdone;
         rsp_in.group_done        = gdone;
         rsp_in.sequence_mismatch = mism;
         rsp_in.size_error        = serr;
         rsp_in.frame_seq_id      = prev_seq_in;
         rsp_in.group_bytes       = grp_bytes_in;
         rsp_in.frames_in_group   = grp_frames_in;

         // Close the group and restart its counts
         if (gdone) begin
            groups_in     = groups_ff + 32'd1;
            grp_frames_in = '0;
            grp_bytes_in  = '0;
         end
         rsp_in.groups_done = groups_in;
      end
   end

   // Update state on each taken item; write the register on a csr transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         fpg_ff           <= LPSD_FPG_RESET;
         payload_phase_ff <= 1'b0;
         frame_count_ff   <= '0;
         frame_size_ff    <= '0;
         seq_shift_ff     <= '0;
         prev_seq_ff      <= '0;
         seq_latched_ff   <= 1'b0;
         grp_frames_ff    <= '0;
         grp_bytes_ff     <= '0;
         groups_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            fpg_ff <= csr_ch.data;
         end
         if (take) begin
            payload_phase_ff <= payload_phase_in;
            frame_count_ff   <= frame_count_in;
            frame_size_ff    <= frame_size_in;
            seq_shift_ff     <= seq_shift_in;
            prev_seq_ff      <= prev_seq_in;
            seq_latched_ff   <= seq_latched_in;
            grp_frames_ff    <= grp_frames_in;
            grp_bytes_ff     <= grp_bytes_in;
            groups_ff        <= groups_in;
         end
         if (pop_ready) begin
            rsp_valid_ff <= pop_valid;
         end
      end
   end

   // Load the result register with each taken item
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.byte_valid        = rsp_ff.byte_valid;
   assign rsp_ch.data_out          = rsp_ff.data_out;
   assign rsp_ch.in_header         = rsp_ff.in_header;
   assign rsp_ch.frame_done        = rsp_ff.frame_done;
   assign rsp_ch.group_done        = rsp_ff.group_done;
   assign rsp_ch.sequence_mismatch = rsp_ff.sequence_mismatch;
   assign rsp_ch.size_error        = rsp_ff.size_error;
   assign rsp_ch.frame_seq_id      = rsp_ff.frame_seq_id;
   assign rsp_ch.group_bytes       = rsp_ff.group_bytes;
   assign rsp_ch.frames_in_group   = rsp_ff.frames_in_group;
   assign rsp_ch.groups_done       = rsp_ff.groups_done;

   `LPSD_ASSERT_NOW(a_hdr_bound, clock, reset, !payload_phase_ff,
                    frame_count_ff < LPSD_HEADER_LEN, "header count past header length")
   `LPSD_ASSERT_NOW(a_pay_bound, clock, reset, payload_phase_ff,
                    frame_count_ff < frame_size_ff, "payload count past frame size")
   `LPSD_ASSERT_NOW(a_grp_frame, clock, reset, rsp_valid_ff && rsp_ff.group_done,
                    rsp_ff.frame_done, "group closed without frame end")
   `LPSD_ASSERT_NOW(a_size_err, clock, reset, rsp_valid_ff && rsp_ff.size_error,
                    rsp_ff.frame_done && rsp_ff.in_header, "size error off last header byte")
   `LPSD_ASSERT_NEXT(a_restart_clr, clock, reset,
                     take && pop_item.kind == LPSD_KIND_RESTART,
                     !payload_phase_ff && frame_count_ff == '0 && groups_ff == '0,
                     "restart left state behind")

endmodule
`default_nettype wire

// ===== rtl/length_prefixed_slice_deframer_top.sv =====
// Top level of the length-prefixed slice deframer.
//
// Channels: req_ch carries one item per transfer (cmd, data_byte); cmd 1
// restarts the run. rsp_ch returns exactly one result per request, in order.
// csr_ch writes frames_per_group (reset value 1); write only while idle.
// A request accepted into the front slot is then written to a queue entry and
// then to the result register, where its result becomes valid.
// Throughput: one byte per clock while rsp_ch.ready stays high; the deframing
// state in the back is updated in the single cycle that an item is taken from the queue.
// Stall: when rsp_ch.ready is low the result register holds, the back stops
// taking items and the queue plus the front slot absorb up to QUEUE_DEPTH+1
// further transfers before req_ch.ready falls.
// Reset (synchronous, active high): queue and result register emptied, all
// frame and group counters cleared, frames_per_group back to 1.
`default_nettype none
module length_prefixed_slice_deframer_top #(
   parameter int unsigned QUEUE_DEPTH = lpsd_pkg::LPSD_QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpsd_req_if.sink   req_ch,
   lpsd_csr_if.sink   csr_ch,
   lpsd_rsp_if.source rsp_ch
);
   import lpsd_pkg::*;

   item_type front_item;
   logic     front_valid;
   logic     front_ready;
   item_type back_item;
   logic     back_valid;
   logic     back_ready;

   // Accept and classify
   lpsd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_item  (front_item),
      .q_valid (front_valid),
      .q_ready (front_ready)
   );

   // Decouple front and back
   lpsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_item   (back_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   // Deframe and report
   lpsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (back_item),
      .pop_valid (back_valid),
      .pop_ready (back_ready),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire
